@@ rtl/slrr_pkg.sv @@
// ----------------------------------------------------------------------------
// slrr_pkg: shared types and constants for the shuffled LCG range generator
// Holds the request kinds, register indexes, reset values and the command
// and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package slrr_pkg;

    localparam int WORD_W   = 32;
    localparam int HALF_W   = 16;
    localparam int ROT_L    = 12;
    localparam int DIV_STEPS = WORD_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [HALF_W-1:0] FOLD_FACTOR = 16'd36969;

    localparam logic [WORD_W-1:0] MULT_RST  = 32'd1103515245;
    localparam logic [WORD_W-1:0] INCR_RST  = 32'd12345;
    localparam logic [WORD_W-1:0] MASK_RST  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SEED_RST  = 32'd1;

    typedef enum logic [2:0] {
        KIND_RESEED = 3'd0,
        KIND_RAW    = 3'd1,
        KIND_POW2   = 3'd2,
        KIND_MOD    = 3'd3,
        KIND_RANGE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CFG_MULT = 2'd0,
        CFG_INCR = 2'd1,
        CFG_MASK = 2'd2,
        CFG_SEED = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic capture;
        logic reseed;
        logic prep;
        logic fold;
        logic mul;
        logic add;
        logic div_start;
        logic div_step;
        logic push;
    } slrr_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       bound_zero;
        logic       div_last;
        logic       out_busy;
    } slrr_stat_t;

endpackage

@@ rtl/slrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// slrr_ctrl: sequencing controller
// Steps one request at a time through decode, fold, multiply, add, the
// iterative remainder and the output load.
// ----------------------------------------------------------------------------
module slrr_ctrl
    import slrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  slrr_stat_t stat,
    output slrr_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_FOLD   = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_ADD    = 9'b000100000,
        S_DSTART = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.prep = 1'b1;
                unique case (stat.kind) inside
                    KIND_RESEED:
                    begin
                        cmd.reseed = 1'b1;
                        state_next = S_IDLE;
                    end
                    KIND_RAW, KIND_POW2: state_next = S_FOLD;
                    KIND_MOD, KIND_RANGE: state_next = S_CHECK;
                    default: state_next = S_IDLE;
                endcase
            end
            S_CHECK:
            begin
                // A zero bound or span returns the low end without advancing.
                state_next = stat.bound_zero ? S_OUT : S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                if (stat.kind == KIND_RAW || stat.kind == KIND_POW2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DSTART;
                end
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ rtl/slrr_dp.sv @@
// ----------------------------------------------------------------------------
// slrr_dp: generator datapath
// Holds the configuration registers, the generator word, the fold and
// multiply pipeline registers, a radix-2 restoring remainder unit and the
// output register.
// ----------------------------------------------------------------------------
module slrr_dp
    import slrr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  slrr_cmd_t                cmd,
    output slrr_stat_t               stat,
    input  logic [2:0]               kind,
    input  logic [WORD_W-1:0]        first_operand,
    input  logic signed [WORD_W-1:0] second_operand,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WORD_W-1:0]        random_value
);

    logic [WORD_W-1:0] mult_reg;
    logic [WORD_W-1:0] incr_reg;
    logic [WORD_W-1:0] mask_reg;
    logic [WORD_W-1:0] word_reg;

    logic [2:0]        kind_reg;
    logic [WORD_W-1:0] op1_reg;
    logic [WORD_W-1:0] op2_reg;
    logic [WORD_W-1:0] bound_reg;
    logic [WORD_W-1:0] low_reg;
    logic [WORD_W-1:0] fold_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg;

    logic [WORD_W-1:0] rot_word;
    logic [WORD_W-1:0] fold_next;
    logic [WORD_W-1:0] bound_next;
    logic [WORD_W-1:0] low_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] pow2_mask;
    logic [WORD_W-1:0] out_value_next;

    // Configuration registers. The start seed only sets the word at reset,
    // so a later write to it has no effect and nothing is stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RST;
            incr_reg <= INCR_RST;
            mask_reg <= MASK_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MULT: mult_reg <= cfg_data;
                CFG_INCR: incr_reg <= cfg_data;
                CFG_MASK: mask_reg <= cfg_data;
                CFG_SEED: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= SEED_RST;
        end
        else if (cmd.reseed)
        begin
            word_reg <= op1_reg;
        end
        else if (cmd.add)
        begin
            word_reg <= (prod_reg + incr_reg) & mask_reg;
        end
    end

    assign rot_word  = {word_reg[WORD_W-ROT_L-1:0], word_reg[WORD_W-1:WORD_W-ROT_L]};
    assign fold_next = {{HALF_W{1'b0}}, FOLD_FACTOR} * {{HALF_W{1'b0}}, rot_word[HALF_W-1:0]}
                     + {{HALF_W{1'b0}}, rot_word[WORD_W-1:HALF_W]};

    // Range bounds: the span is taken from the lower end to the upper end.
    always_comb
    begin
        if (kind_reg == KIND_RANGE)
        begin
            if ($signed(op1_reg) < $signed(op2_reg))
            begin
                bound_next = op2_reg - op1_reg;
                low_next   = op1_reg;
            end
            else
            begin
                bound_next = op1_reg - op2_reg;
                low_next   = op2_reg;
            end
        end
        else
        begin
            bound_next = op1_reg;
            low_next   = '0;
        end
    end

    assign trial    = {rem_reg, quo_reg[WORD_W-1]};
    assign rem_next = (trial >= {1'b0, bound_reg}) ? 32'(trial - {1'b0, bound_reg})
                                                   : trial[WORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            op1_reg  <= first_operand;
            op2_reg  <= second_operand;
        end
        if (cmd.prep)
        begin
            bound_reg <= bound_next;
            low_reg   <= low_next;
        end
        if (cmd.fold)
        begin
            fold_reg <= fold_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= 32'(mult_reg * fold_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= word_reg;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.push)
        begin
            out_value_reg <= out_value_next;
        end
    end

    assign pow2_mask = ~({WORD_W{1'b1}} << op1_reg[CNT_W-1:0]);

    always_comb
    begin
        case (kind_reg) inside
            KIND_POW2:
            begin
                if (op1_reg[WORD_W-1:CNT_W] != '0)
                begin
                    out_value_next = word_reg;
                end
                else
                begin
                    out_value_next = word_reg & pow2_mask;
                end
            end
            KIND_MOD, KIND_RANGE:
            begin
                if (bound_reg == '0)
                begin
                    out_value_next = low_reg;
                end
                else
                begin
                    out_value_next = rem_reg + low_reg;
                end
            end
            default: out_value_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_value_reg;

    assign stat.kind       = kind_reg;
    assign stat.bound_zero = (bound_reg == '0);
    assign stat.div_last   = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign stat.out_busy   = out_valid_reg && !out_ready;

endmodule

@@ rtl/shuffled_lcg_random_ranges_top.sv @@
// ----------------------------------------------------------------------------
// shuffled_lcg_random_ranges_top: shuffled 32-bit LCG with range helpers
//
//   Channel  Signals                                      Direction
//   in       in_valid/in_ready, kind, first_operand,      request
//            second_operand
//   out      out_valid/out_ready, random_value            result
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     register write
//
// A reseed passes decode only; a raw or masked draw passes decode, fold,
// multiply and add; a modulo or range draw also runs the 32 steps of the
// one-bit-per-cycle remainder unit; a zero bound skips straight to output.
// Reset loads the register defaults and the generator word 1.
// A result waits in the output register; the next request is taken while it
// waits, and a request stalls only in its last cycle if the output is full.
// ----------------------------------------------------------------------------
module shuffled_lcg_random_ranges_top
    import slrr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               kind,
    input  logic [WORD_W-1:0]        first_operand,
    input  logic signed [WORD_W-1:0] second_operand,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [WORD_W-1:0]        random_value,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [WORD_W-1:0]        cfg_data
);

    slrr_cmd_t  cmd;
    slrr_stat_t stat;

    // Register writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;

    slrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    slrr_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (kind),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .random_value   (random_value)
    );

endmodule

@@ rtl/slrr_checker.sv @@
// ----------------------------------------------------------------------------
// slrr_checker: port-level checks for the shuffled LCG range generator
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module slrr_checker
    import slrr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [2:0]        kind,
    input logic              out_valid,
    input logic              out_ready,
    input logic [WORD_W-1:0] random_value
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_value))
        else $error("result changed or dropped while stalled");

    // Requests are handled one at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");

    // A reseed or an unused kind frees the input right after the decode state.
    a_short_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == KIND_RESEED || kind > KIND_RANGE)
        |=> ##1 in_ready)
        else $error("reseed or unused kind did not return to idle");

    // A new result is only loaded while no request can be taken.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a request in flight");

endmodule

bind shuffled_lcg_random_ranges_top slrr_checker u_slrr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .random_value (random_value)
);
